// File: rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
// Holds the fixed-point widths, the arctangent table and the queue item type.
// Depends on nothing; the converter's modules and the testbench import it.
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_FRAC_DEF    = 13;
    localparam int ACC_FRAC          = 30;
    localparam int TBL_LEN           = 24;

    localparam int ARG_W   = 34;
    localparam int CW      = 38;
    localparam int ZW      = 35;
    localparam int S_W     = 30;
    localparam int C_W     = 29;
    localparam int SQ_STEPS = C_W;
    localparam int SQ_W    = 2 * C_W - 1;
    localparam int MARG_W  = 13;

    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;

    localparam logic signed [ZW-1:0] PI_ACC      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_ACC = 35'sd1686629713;
    localparam logic signed [ARG_W-1:0] ONE_Q28  = 34'sd268435456;

    localparam logic signed [ZW-1:0] ATAN_TBL [TBL_LEN] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128
    };

    typedef struct packed {
        logic signed [S_W-1:0]   s;
        logic        [C_W-1:0]   c;
        logic signed [ARG_W-1:0] yn_y;
        logic signed [ARG_W-1:0] yn_x;
        logic signed [ARG_W-1:0] rl_y;
        logic signed [ARG_W-1:0] rl_x;
        logic signed [ARG_W-1:0] yl_y;
        logic signed [ARG_W-1:0] yl_x;
    } t_item;

endpackage

// File: rtl/qte_in_if.sv
// Input channel carrying one quaternion per transaction.
// Valid/ready handshake; depends on nothing.
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

// File: rtl/qte_out_if.sv
// Output channel carrying roll, pitch, yaw and the gimbal lock flag.
// Valid/ready handshake; depends on nothing.
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [16:0] yaw_angle;
    logic               gimbal_lock;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, output gimbal_lock, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, input gimbal_lock, output ready);
endinterface

// File: rtl/quaternion_to_euler_angles.sv
// Top level of the quaternion to roll/pitch/yaw converter with its register port.
// Depends on qte_pkg, qte_in_if, qte_out_if, qte_front, qte_queue and qte_back.
//
// A quaternion enters on in_ch as one transaction; one transaction with roll,
// pitch, yaw and the gimbal lock flag leaves on out_ch for each of them, in order.
// The block takes one quaternion per cycle while in_ch.ready is high. Each
// quaternion passes through the 29-step square root pipeline of the front and
// then the four CORDIC pipelines of the back, which run in parallel. A four-entry
// queue sits between the two parts. When the receiver stalls, the back holds its
// result and stops; the front keeps filling the queue and then lowers in_ch.ready.
// Register lock_margin lies at byte address 0 of the APB port and resets to 1;
// it is to be written by the user only while the block is idle; the block
// itself does not enforce this.
// Reset is synchronous and empties both pipelines and the queue.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_in_if.sink      in_ch,
    qte_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qte_pkg::*;

    logic [MARG_W-1:0] r_lock_margin;
    logic              push, full, pop, empty;
    t_item             f_item, q_item;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : 32'(r_lock_margin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_margin <= MARG_W'(1);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_lock_margin <= pwdata[MARG_W-1:0];
        end
    end

    qte_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_push(push), .o_item(f_item), .i_full(full)
    );

    qte_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(f_item), .o_full(full),
        .i_pop(pop), .o_item(q_item), .o_empty(empty)
    );

    qte_back #(
        .CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(q_item), .i_empty(empty),
        .o_pop(pop), .i_lock_margin(r_lock_margin), .out_ch(out_ch)
    );

endmodule

// File: rtl/qte_front.sv
// Front pipeline: products, sine clamp, atan2 operands and the pipelined square root.
// Depends on qte_pkg and qte_in_if.
module qte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qte_in_if.sink        in_ch,
    output logic          o_push,
    output qte_pkg::t_item o_item,
    input  logic          i_full
);
    import qte_pkg::*;

    localparam int NS = SQ_STEPS;

    logic en;

    logic               r_va;
    logic signed [15:0] r_x, r_y, r_z, r_w;

    logic               r_vb;
    logic signed [31:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    logic  r_vc;
    t_item r_itc;
    t_item n_itc;
    logic signed [ARG_W-1:0] s_raw;

    logic [C_W-1:0]   s_abs;
    logic [2*C_W-1:0] s_sq;

    logic            r_vs  [NS+1];
    logic [SQ_W-1:0] r_rem [NS+1];
    logic [SQ_W:0]   r_res [NS+1];
    t_item           r_it  [NS+1];

    assign en          = !(r_vs[NS] && i_full);
    assign in_ch.ready = en;
    assign o_push      = en && r_vs[NS];

    always_comb begin
        o_item   = r_it[NS];
        o_item.c = r_res[NS][C_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (en) begin
            r_va <= in_ch.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x  <= in_ch.quat_x;
            r_y  <= in_ch.quat_y;
            r_z  <= in_ch.quat_z;
            r_w  <= in_ch.quat_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_ww <= r_w * r_w;
            r_xy <= r_x * r_y;
            r_xz <= r_x * r_z;
            r_yz <= r_y * r_z;
            r_wx <= r_w * r_x;
            r_wy <= r_w * r_y;
            r_wz <= r_w * r_z;
            r_itc <= n_itc;
        end
    end

    always_comb begin
        n_itc = '0;
        s_raw = (ARG_W'(r_wy) - ARG_W'(r_xz)) <<< 1;
        if (s_raw > ONE_Q28) begin
            n_itc.s = S_W'(ONE_Q28);
        end else if (s_raw < -ONE_Q28) begin
            n_itc.s = S_W'(-ONE_Q28);
        end else begin
            n_itc.s = S_W'(s_raw);
        end
        n_itc.yn_y = (ARG_W'(r_xy) + ARG_W'(r_wz)) <<< 1;
        n_itc.yn_x = ARG_W'(r_xx) - ARG_W'(r_yy) - ARG_W'(r_zz) + ARG_W'(r_ww);
        n_itc.rl_y = (ARG_W'(r_wx) + ARG_W'(r_yz)) <<< 1;
        n_itc.rl_x = ARG_W'(r_ww) - ARG_W'(r_xx) - ARG_W'(r_yy) + ARG_W'(r_zz);
        n_itc.yl_y = (ARG_W'(r_yz) - ARG_W'(r_wx)) <<< 1;
        n_itc.yl_x = (ARG_W'(r_xz) + ARG_W'(r_wy)) <<< 1;
    end

    assign s_abs = (r_itc.s < 0) ? C_W'(-r_itc.s) : C_W'(r_itc.s);
    assign s_sq  = s_abs * s_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else if (en) begin
            r_vs[0] <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= {1'b1, {(SQ_W-1){1'b0}}} - s_sq[SQ_W-1:0];
            r_res[0] <= '0;
            r_it[0]  <= r_itc;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sq
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (NS - 1 - j));
        logic [SQ_W:0] trial;
        logic          ge;

        assign trial = r_res[j] + BIT;
        assign ge    = {1'b0, r_rem[j]} >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[j+1] <= 1'b0;
            end else if (en) begin
                r_vs[j+1] <= r_vs[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j+1] <= ge ? (r_rem[j] - trial[SQ_W-1:0]) : r_rem[j];
                r_res[j+1] <= ge ? ((r_res[j] >> 1) + BIT) : (r_res[j] >> 1);
                r_it[j+1]  <= r_it[j];
            end
        end
    end

endmodule

// File: rtl/qte_queue.sv
// Short queue between the front and back pipelines.
// Depends on qte_pkg for the item type and depth.
module qte_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qte_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output qte_pkg::t_item o_item,
    output logic           o_empty
);
    import qte_pkg::*;

    t_item           r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QA_W:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == (QA_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: rtl/qte_cordic.sv
// Pipelined vectoring CORDIC returning atan2(y, x) in Q.30 radians.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [qte_pkg::ARG_W-1:0] i_y,
    input  logic signed [qte_pkg::ARG_W-1:0] i_x,
    output logic signed [qte_pkg::ZW-1:0]    o_z
);
    import qte_pkg::*;

    logic signed [CW-1:0] r_x [STAGES+1];
    logic signed [CW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic                 r_zero [STAGES+1];

    logic signed [CW-1:0] xe, ye;

    assign xe = CW'(i_x);
    assign ye = CW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (xe < 0) begin
                if (ye >= 0) begin
                    r_x[0] <= ye;
                    r_y[0] <= -xe;
                    r_z[0] <= HALF_PI_ACC;
                end else begin
                    r_x[0] <= -ye;
                    r_y[0] <= xe;
                    r_z[0] <= -HALF_PI_ACC;
                end
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_it
        logic signed [CW-1:0] xs, ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ATAN_TBL[i];
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ATAN_TBL[i];
                end
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

// File: rtl/qte_back.sv
// Back pipeline: four parallel CORDICs, gimbal lock decision and output register.
// Depends on qte_pkg, qte_cordic and qte_out_if.
module qte_back #(
    parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qte_pkg::t_item             i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic [qte_pkg::MARG_W-1:0] i_lock_margin,
    qte_out_if.source                  out_ch
);
    import qte_pkg::*;

    localparam int NV = CORDIC_STAGES + 1;
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] RND    = ZW'(1) <<< (SH - 1);
    localparam logic signed [ZW-1:0] HALF_O = (HALF_PI_ACC + RND) >>> SH;

    logic en;
    logic r_v [NV];

    logic signed [ARG_W-1:0] p_y, p_x;
    logic signed [ZW-1:0]    z_p, z_yn, z_rl, z_yl;

    logic signed [ZW-1:0] pitch_o, mag, marg, yaw_l;
    logic                 lock;

    logic                 r_v1;
    logic signed [ZW-1:0] r_pitch_o, r_yaw, r_roll;
    logic                 r_lock;
    logic signed [ZW-1:0] roll_o, yaw_o;

    logic               r_ov;
    logic signed [15:0] r_roll_q;
    logic signed [14:0] r_pitch_q;
    logic signed [16:0] r_yaw_q;
    logic               r_lock_q;

    assign en    = !(r_ov && !out_ch.ready);
    assign o_pop = en && !i_empty;

    assign p_y = ARG_W'(i_item.s);
    assign p_x = ARG_W'(i_item.c);

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_y(p_y), .i_x(p_x), .o_z(z_p)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw_n (
        .i_clk(i_clk), .i_en(en), .i_y(i_item.yn_y), .i_x(i_item.yn_x), .o_z(z_yn)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_y(i_item.rl_y), .i_x(i_item.rl_x), .o_z(z_rl)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw_l (
        .i_clk(i_clk), .i_en(en), .i_y(i_item.yl_y), .i_x(i_item.yl_x), .o_z(z_yl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) begin
                r_v[k] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= o_pop;
            for (int k = 1; k < NV; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_v1 <= r_v[NV-1];
            r_ov <= r_v1;
        end
    end

    assign pitch_o = (z_p + RND) >>> SH;
    assign mag     = (pitch_o < 0) ? -pitch_o : pitch_o;
    assign marg    = ZW'(i_lock_margin);
    assign lock    = !((HALF_O - mag) > marg);
    assign yaw_l   = (z_p < 0) ? (PI_ACC - z_yl) : z_yl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch_o <= pitch_o;
            r_lock    <= lock;
            r_yaw     <= lock ? yaw_l : z_yn;
            r_roll    <= lock ? '0 : z_rl;
        end
    end

    assign roll_o = (r_roll + RND) >>> SH;
    assign yaw_o  = (r_yaw + RND) >>> SH;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll_q  <= roll_o[15:0];
            r_pitch_q <= r_pitch_o[14:0];
            r_yaw_q   <= yaw_o[16:0];
            r_lock_q  <= r_lock;
        end
    end

    assign out_ch.valid       = r_ov;
    assign out_ch.roll_angle  = r_roll_q;
    assign out_ch.pitch_angle = r_pitch_q;
    assign out_ch.yaw_angle   = r_yaw_q;
    assign out_ch.gimbal_lock = r_lock_q;

endmodule

// File: rtl/qte_checker.sv
// Port-level checks for the converter, attached to the top level by a bind.
// Depends only on the top level's ports.
module qte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_roll,
    input logic signed [14:0] i_pitch,
    input logic signed [16:0] i_yaw,
    input logic               i_lock,
    input logic               i_pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_roll)
            && $stable(i_pitch) && $stable(i_yaw) && $stable(i_lock))
        else $error("stalled result changed");

    a_lock_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_lock |-> i_roll == '0)
        else $error("roll not zero under gimbal lock");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("register port not ready");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready),
    .i_roll(out_ch.roll_angle),
    .i_pitch(out_ch.pitch_angle),
    .i_yaw(out_ch.yaw_angle),
    .i_lock(out_ch.gimbal_lock),
    .i_pready(pready)
);

// File: bench/tb_quaternion_to_euler_angles.sv
// Self-checking testbench for quaternion_to_euler_angles: random and directed
// quaternions, random idling on both channels, lock_margin reprogrammed over APB.
// Depends on qte_pkg, qte_in_if, qte_out_if and the RTL of the converter.
module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [16:0] yaw;
        logic               lock;
    } t_euler;

    localparam int  LAT        = CORDIC_STAGES_DEF + 37;
    localparam int  MAX_CYCLES = 400000;
    localparam logic [2:0] ADDR_LOCK_MARGIN = 3'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qte_in_if  in_ch();
    qte_out_if out_ch();

    quaternion_to_euler_angles DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_euler      expected_angles[$];
    logic [12:0] margin;
    int          errors;
    int          cycles;
    int          idle_pct;
    logic        rx_enable;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint atan2_cordic(input longint y_in, input longint x_in);
        longint xv;
        longint yv;
        longint zv;
        longint t;
        longint xs;
        longint ys;
        xv = x_in;
        yv = y_in;
        zv = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                t = xv; xv = yv; yv = -t; zv = HALF_PI_ACC;
            end else begin
                t = xv; xv = -yv; yv = t; zv = -HALF_PI_ACC;
            end
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            xs = shr(xv, i);
            ys = shr(yv, i);
            if (yv >= 0) begin
                xv += ys; yv -= xs; zv += ATAN_TBL[i];
            end else begin
                xv -= ys; yv += xs; zv -= ATAN_TBL[i];
            end
        end
        return zv;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint to_q13(input longint a);
        return (a + (64'sd1 << 16)) >>> 17;
    endfunction

    function automatic t_euler convert(input logic signed [15:0] qx, input logic signed [15:0] qy,
                                       input logic signed [15:0] qz, input logic signed [15:0] qw);
        longint x, y, z, w, s, c, p, r, yw, po, mag;
        logic lk;
        t_euler e;
        x = qx; y = qy; z = qz; w = qw;
        s = 2 * (w * y - x * z);
        if (s > 64'sd268435456) s = 64'sd268435456;
        if (s < -64'sd268435456) s = -64'sd268435456;
        c = floor_sqrt((64'd1 << 56) - longint'(s * s));
        p = atan2_cordic(s, c);
        po = to_q13(p);
        mag = po < 0 ? -po : po;
        lk = !((to_q13(HALF_PI_ACC) - mag) > longint'(margin));
        if (!lk) begin
            yw = atan2_cordic(2 * (x * y + w * z), x*x - y*y - z*z + w*w);
            r = atan2_cordic(2 * (w * x + y * z), w*w - x*x - y*y + z*z);
        end else begin
            yw = atan2_cordic(2 * (y * z) - 2 * (x * w), 2 * (x * z) + 2 * (y * w));
            r = 0;
            if (p < 0) yw = PI_ACC - yw;
        end
        e.roll = 16'(to_q13(r));
        e.pitch = 15'(po);
        e.yaw = 17'(to_q13(yw));
        e.lock = lk;
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_angles.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = expected_angles.pop_front();
                if (out_ch.roll_angle !== want.roll) report("roll", out_ch.roll_angle, want.roll);
                if (out_ch.pitch_angle !== want.pitch)
                    report("pitch", out_ch.pitch_angle, want.pitch);
                if (out_ch.yaw_angle !== want.yaw) report("yaw", out_ch.yaw_angle, want.yaw);
                if (out_ch.gimbal_lock !== want.lock)
                    report("lock", out_ch.gimbal_lock, want.lock);
            end
        end
        if (rx_enable) begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    task automatic send_quat(input logic [15:0] qx, input logic [15:0] qy,
                             input logic [15:0] qz, input logic [15:0] qw);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.quat_x <= qx;
        in_ch.quat_y <= qy;
        in_ch.quat_z <= qz;
        in_ch.quat_w <= qw;
        expected_angles.insert(expected_angles.size(), convert(qx, qy, qz, qw));
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_margin(input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_LOCK_MARGIN;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        margin = value[12:0];
    endtask

    function automatic logic [15:0] unit_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic test_directed();
        logic [15:0] ext[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_quat(16'h0000, 16'h2D41, 16'h0000, 16'h2D41);
        send_quat(16'h0000, 16'hD2BF, 16'h0000, 16'h2D41);
        send_quat(16'h1000, 16'h2D41, 16'h1000, 16'h2D41);
        send_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'hC000);
        for (int i = 0; i < 10; i++)
            send_quat(ext[3'($urandom_range(5))], ext[3'($urandom_range(5))],
                      ext[3'($urandom_range(5))], ext[3'($urandom_range(5))]);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: begin
                    logic [15:0] a;
                    logic [15:0] b;
                    a = unit_comp();
                    b = unit_comp();
                    send_quat(a, b, a ^ 16'($urandom_range(63)), b + 16'($urandom_range(63)));
                end
                default: send_quat(unit_comp(), unit_comp(), unit_comp(), unit_comp());
            endcase
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        margin = 13'd1;
        idle_pct = 37;
        rx_enable = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        in_ch.quat_w = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        drain();
        write_margin(32'hFFFF_E000);
        test_directed();
        test_random(300);
        drain();
        write_margin(32'd8191);
        test_random(300);
        drain();
        write_margin(32'd200);
        idle_pct = 0;
        test_random(400);
        idle_pct = 37;
        drain();
        write_margin(32'd40);
        test_directed();
        test_random(550);
        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
